@@ src/cfp_pkg.sv @@
`timescale 1ns / 1ps

package cfp_pkg;

	// Default longest field, in bytes
	localparam int MAX_FIELD_LEN = 16;

	// Framing characters
	localparam logic [7:0] CHAR_M     = 8'h4D;
	localparam logic [7:0] CHAR_J     = 8'h4A;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	// Result item kinds
	localparam logic [1:0] PART_CMD = 2'd0;
	localparam logic [1:0] PART_PAR = 2'd1;
	localparam logic [1:0] PART_END = 2'd2;

	typedef enum logic [2:0] {
		PS_HUNT_M1   = 3'd0,
		PS_HUNT_M2   = 3'd1,
		PS_HUNT_M3   = 3'd2,
		PS_HUNT_J    = 3'd3,
		PS_HEAD_COL  = 3'd4,
		PS_COMMAND   = 3'd5,
		PS_PARAMETER = 3'd6
	} parse_state_t;

	typedef enum logic [1:0] {
		EM_IDLE = 2'd0,
		EM_READ = 2'd1,
		EM_LOAD = 2'd2,
		EM_SHOW = 2'd3
	} emit_state_t;

	// Write strobes from the parser into the two field stores
	typedef struct packed {
		logic       cmd_we;
		logic       par_we;
		logic [7:0] data;
	} ram_wr_t;

endpackage

@@ src/cfp_ram.sv @@
`timescale 1ns / 1ps

module cfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/cfp_parse.sv @@
`timescale 1ns / 1ps

module cfp_parse #(
	parameter int MAX_LEN = cfp_pkg::MAX_FIELD_LEN,
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int CW = $clog2(MAX_LEN + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	output cfp_pkg::ram_wr_t wr,
	output logic [AW-1:0]   cmd_waddr,
	output logic [AW-1:0]   par_waddr,
	output logic            start,
	output logic [CW-1:0]   cmd_len,
	output logic [CW-1:0]   par_len
);

	cfp_pkg::parse_state_t state_q, state_d;
	logic [CW-1:0] cmd_cnt_q, cmd_cnt_d;
	logic [CW-1:0] par_cnt_q, par_cnt_d;

	// State and field counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cfp_pkg::PS_HUNT_M1;
			cmd_cnt_q <= '0;
			par_cnt_q <= '0;
		end else if (accept) begin
			state_q   <= state_d;
			cmd_cnt_q <= cmd_cnt_d;
			par_cnt_q <= par_cnt_d;
		end
	end

	// Decode the byte against the current framing state
	always_comb begin
		state_d   = state_q;
		cmd_cnt_d = cmd_cnt_q;
		par_cnt_d = par_cnt_q;
		wr.cmd_we = 1'b0;
		wr.par_we = 1'b0;
		wr.data   = rx_byte;
		start     = 1'b0;
		unique case (state_q)
			cfp_pkg::PS_HUNT_M2: begin
				state_d = (rx_byte == cfp_pkg::CHAR_M) ? cfp_pkg::PS_HUNT_M3
				                                       : cfp_pkg::PS_HUNT_M1;
			end
			cfp_pkg::PS_HUNT_M3: begin
				state_d = (rx_byte == cfp_pkg::CHAR_M) ? cfp_pkg::PS_HUNT_J
				                                       : cfp_pkg::PS_HUNT_M1;
			end
			cfp_pkg::PS_HUNT_J: begin
				state_d = (rx_byte == cfp_pkg::CHAR_J) ? cfp_pkg::PS_HEAD_COL
				                                       : cfp_pkg::PS_HUNT_M1;
			end
			cfp_pkg::PS_HEAD_COL: begin
				if (rx_byte == cfp_pkg::CHAR_COLON) begin
					state_d   = cfp_pkg::PS_COMMAND;
					cmd_cnt_d = '0;
				end else begin
					state_d = cfp_pkg::PS_HUNT_M1;
				end
			end
			cfp_pkg::PS_COMMAND: begin
				if (rx_byte == cfp_pkg::CHAR_COLON) begin
					state_d   = cfp_pkg::PS_PARAMETER;
					par_cnt_d = '0;
				end else if (cmd_cnt_q < CW'(MAX_LEN)) begin
					wr.cmd_we = accept;
					cmd_cnt_d = cmd_cnt_q + 1'b1;
				end else begin
					state_d = cfp_pkg::PS_HUNT_M1;
				end
			end
			cfp_pkg::PS_PARAMETER: begin
				if (rx_byte == cfp_pkg::CHAR_CR) begin
					state_d = cfp_pkg::PS_PARAMETER;
				end else if (rx_byte == cfp_pkg::CHAR_LF) begin
					state_d = cfp_pkg::PS_HUNT_M1;
					start   = accept;
				end else if (par_cnt_q < CW'(MAX_LEN)) begin
					wr.par_we = accept;
					par_cnt_d = par_cnt_q + 1'b1;
				end else begin
					state_d = cfp_pkg::PS_HUNT_M1;
				end
			end
			default: begin
				state_d = (rx_byte == cfp_pkg::CHAR_M) ? cfp_pkg::PS_HUNT_M2
				                                       : cfp_pkg::PS_HUNT_M1;
			end
		endcase
	end

	assign cmd_waddr = cmd_cnt_q[AW-1:0];
	assign par_waddr = par_cnt_q[AW-1:0];
	assign cmd_len   = cmd_cnt_q;
	assign par_len   = par_cnt_q;

endmodule

@@ src/cfp_emit.sv @@
`timescale 1ns / 1ps

module cfp_emit #(
	parameter int MAX_LEN = cfp_pkg::MAX_FIELD_LEN,
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int CW = $clog2(MAX_LEN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] cmd_len,
	input  logic [CW-1:0] par_len,
	output logic          busy,
	output logic          cmd_re,
	output logic          par_re,
	output logic [AW-1:0] raddr,
	input  logic [7:0]    cmd_rdata,
	input  logic [7:0]    par_rdata,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    part,
	output logic [7:0]    data_byte,
	output logic [3:0]    position,
	output logic [4:0]    command_length,
	output logic [4:0]    parameter_length,
	output logic          last
);

	cfp_pkg::emit_state_t state_q, state_d;
	logic [1:0]    phase_q, phase_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] cmd_len_q, par_len_q;
	logic [1:0]    part_q;
	logic [7:0]    data_q;
	logic [3:0]    pos_q;
	logic          last_q;
	logic [CW-1:0] idx_next;

	assign idx_next = CW'(idx_q) + 1'b1;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfp_pkg::EM_IDLE;
			phase_q <= cfp_pkg::PART_CMD;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	// Capture the frame lengths at the line feed
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_len_q <= cmd_len;
			par_len_q <= par_len;
		end
	end

	// Output register, loaded in the load state that follows the store read
	always_ff @(posedge clk) begin
		if (state_q == cfp_pkg::EM_LOAD) begin
			part_q <= phase_q;
			pos_q  <= (phase_q == cfp_pkg::PART_END) ? 4'd0 : 4'(idx_q);
			last_q <= (phase_q == cfp_pkg::PART_END);
			case (phase_q)
				cfp_pkg::PART_CMD: data_q <= cmd_rdata;
				cfp_pkg::PART_PAR: data_q <= par_rdata;
				default:           data_q <= 8'd0;
			endcase
		end
	end

	// Walk command bytes, parameter bytes, then the end item
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		idx_d   = idx_q;
		unique case (state_q)
			cfp_pkg::EM_IDLE: begin
				if (start) begin
					idx_d = '0;
					if (cmd_len != '0) begin
						phase_d = cfp_pkg::PART_CMD;
						state_d = cfp_pkg::EM_READ;
					end else if (par_len != '0) begin
						phase_d = cfp_pkg::PART_PAR;
						state_d = cfp_pkg::EM_READ;
					end else begin
						phase_d = cfp_pkg::PART_END;
						state_d = cfp_pkg::EM_LOAD;
					end
				end
			end
			cfp_pkg::EM_READ: begin
				state_d = cfp_pkg::EM_LOAD;
			end
			cfp_pkg::EM_LOAD: begin
				state_d = cfp_pkg::EM_SHOW;
			end
			cfp_pkg::EM_SHOW: begin
				if (!out_stall) begin
					idx_d = '0;
					if (phase_q == cfp_pkg::PART_CMD && idx_next < cmd_len_q) begin
						idx_d   = idx_next[AW-1:0];
						state_d = cfp_pkg::EM_READ;
					end else if (phase_q == cfp_pkg::PART_CMD && par_len_q != '0) begin
						phase_d = cfp_pkg::PART_PAR;
						state_d = cfp_pkg::EM_READ;
					end else if (phase_q == cfp_pkg::PART_PAR && idx_next < par_len_q) begin
						idx_d   = idx_next[AW-1:0];
						state_d = cfp_pkg::EM_READ;
					end else if (phase_q != cfp_pkg::PART_END) begin
						phase_d = cfp_pkg::PART_END;
						state_d = cfp_pkg::EM_LOAD;
					end else begin
						state_d = cfp_pkg::EM_IDLE;
					end
				end
			end
			default: state_d = cfp_pkg::EM_IDLE;
		endcase
	end

	assign busy   = (state_q != cfp_pkg::EM_IDLE);
	assign cmd_re = (state_q == cfp_pkg::EM_READ) && (phase_q == cfp_pkg::PART_CMD);
	assign par_re = (state_q == cfp_pkg::EM_READ) && (phase_q == cfp_pkg::PART_PAR);
	assign raddr  = idx_q;

	assign out_valid        = (state_q == cfp_pkg::EM_SHOW);
	assign part             = part_q;
	assign data_byte        = data_q;
	assign position         = pos_q;
	assign command_length   = 5'(cmd_len_q);
	assign parameter_length = 5'(par_len_q);
	assign last             = last_q;

endmodule

@@ src/command_frame_parser_unit.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// rx      | in        | rx_valid / rx_stall   | rx_byte
// out     | out       | out_valid / out_stall | part, data_byte, position,
//         |           |                       | command_length, parameter_length, last
//
// A byte is taken while rx_valid is high and rx_stall is low; the framing state and lengths update on it
// and field bytes go straight into their store.
// A line feed starts a run of result items, each a store read, an output load and a show (the end
// item skips the store read); rx_stall stays high until the end item is taken, also while out_stall
// holds a result beat.
// Reset puts the parser back to the hunt for the first sync byte; the stores need no clearing.
// rx_stall is high for the whole run, which keeps store writes clear of the reads.

module command_frame_parser_unit #(
	parameter int MAX_LEN = cfp_pkg::MAX_FIELD_LEN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] part,
	output logic [7:0] data_byte,
	output logic [3:0] position,
	output logic [4:0] command_length,
	output logic [4:0] parameter_length,
	output logic       last
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	cfp_pkg::ram_wr_t wr;
	logic          accept;
	logic          busy;
	logic          start;
	logic [AW-1:0] cmd_waddr, par_waddr, raddr;
	logic [CW-1:0] cmd_len, par_len;
	logic          cmd_re, par_re;
	logic [7:0]    cmd_rdata, par_rdata;

	// Hold off input while a frame is being sent out
	assign rx_stall = busy;
	assign accept   = rx_valid && !busy;

	cfp_parse #(.MAX_LEN(MAX_LEN)) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.wr        (wr),
		.cmd_waddr (cmd_waddr),
		.par_waddr (par_waddr),
		.start     (start),
		.cmd_len   (cmd_len),
		.par_len   (par_len)
	);

	cfp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_cmd_ram (
		.clk   (clk),
		.we    (wr.cmd_we),
		.waddr (cmd_waddr),
		.wdata (wr.data),
		.re    (cmd_re),
		.raddr (raddr),
		.rdata (cmd_rdata)
	);

	cfp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_par_ram (
		.clk   (clk),
		.we    (wr.par_we),
		.waddr (par_waddr),
		.wdata (wr.data),
		.re    (par_re),
		.raddr (raddr),
		.rdata (par_rdata)
	);

	cfp_emit #(.MAX_LEN(MAX_LEN)) u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.cmd_len          (cmd_len),
		.par_len          (par_len),
		.busy             (busy),
		.cmd_re           (cmd_re),
		.par_re           (par_re),
		.raddr            (raddr),
		.cmd_rdata        (cmd_rdata),
		.par_rdata        (par_rdata),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.part             (part),
		.data_byte        (data_byte),
		.position         (position),
		.command_length   (command_length),
		.parameter_length (parameter_length),
		.last             (last)
	);

endmodule

@@ src/cfp_checker.sv @@
`timescale 1ns / 1ps

module cfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] part,
	input logic [7:0] data_byte,
	input logic [3:0] position,
	input logic [4:0] command_length,
	input logic [4:0] parameter_length,
	input logic       last
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(part) && $stable(data_byte)
			&& $stable(position) && $stable(command_length)
			&& $stable(parameter_length) && $stable(last))
		else $error("stalled result beat changed");

	// No byte taken while a frame is going out
	a_rx_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rx_stall)
		else $error("input open during frame output");

	// End beat carries no byte and closes the run
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> part == cfp_pkg::PART_END && data_byte == 8'd0
			&& position == 4'd0)
		else $error("malformed end beat");

	// Byte beats never flag last
	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (part == cfp_pkg::PART_CMD || part == cfp_pkg::PART_PAR) |-> !last)
		else $error("byte beat flagged last");

	// After the end beat is taken the output goes quiet
	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result beat after end of frame");

endmodule

bind command_frame_parser_unit cfp_checker u_cfp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rx_stall         (rx_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.part             (part),
	.data_byte        (data_byte),
	.position         (position),
	.command_length   (command_length),
	.parameter_length (parameter_length),
	.last             (last)
);
